// ===== hw/rtl/psrb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psrb_pkg
// Shared codes and register reset values of the packet reorder buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package psrb_pkg;

	typedef enum logic [1:0] {
		REQ_ARRIVE = 2'd0,
		REQ_TICK   = 2'd1,
		REQ_DRAIN  = 2'd2
	} req_code_t;

	typedef enum logic [1:0] {
		REG_LOST_TIMEOUT   = 2'd0,
		REG_MAX_DIFFERENCE = 2'd1,
		REG_MAX_RELEASES   = 2'd2
	} reg_idx_t;

	localparam logic KIND_PACKET = 1'b0;
	localparam logic KIND_END    = 1'b1;

	localparam logic [15:0] LOST_TIMEOUT_RST   = 16'd50;
	localparam logic [31:0] MAX_DIFFERENCE_RST = 32'd1000;
	localparam logic [5:0]  MAX_RELEASES_RST   = 6'd63;

endpackage

`default_nettype wire

// ===== hw/rtl/psrb_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psrb_if
// Request and response channels of the packet reorder buffer.
// ----------------------------------------------------------------------------
`default_nettype none

interface psrb_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic [31:0] seq_num;
	logic [15:0] payload_tag;

	modport source (output valid, req_type, seq_num, payload_tag, input ready);
	modport sink (input valid, req_type, seq_num, payload_tag, output ready);
endinterface

interface psrb_rsp_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [31:0] out_seq;
	logic [15:0] out_tag;
	logic [31:0] loss_count;
	logic [15:0] drop_count;
	logic        last;

	modport source (output valid, kind, out_seq, out_tag, loss_count, drop_count, last,
		input ready);
	modport sink (input valid, kind, out_seq, out_tag, loss_count, drop_count, last,
		output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/packet_sequence_reorder_buffer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packet_sequence_reorder_buffer_unit
// Reorders numbered packets held in two sorted ring buffers in memory.
// ----------------------------------------------------------------------------
// Each store is a ring buffer in a one-port-read, one-port-write memory kept
// in ascending order, so the lowest number sits at the head and a removal is
// a head step. An arrival into an empty or full store ends at its first
// insert state; else the insert shifts each stored entry with a higher number
// up one place, one memory read and write per cycle. Merging the side store
// costs nothing: the main store is empty then, so the two simply swap roles.
// A drain looks at head entries in turn (request, then head check), closes
// with an end word, stops at a hole until the lost timeout runs out, and waits
// while the output register is full. No clearing pass after reset.
`default_nettype none

module packet_sequence_reorder_buffer_unit #(
	parameter int HEAP_DEPTH = 64,
	parameter int TAG_BITS   = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	psrb_req_if.sink         req,
	psrb_rsp_if.source       rsp
);

	localparam int AW = $clog2(HEAP_DEPTH);
	localparam int CW = $clog2(HEAP_DEPTH + 1);
	localparam int TW = (TAG_BITS < 16) ? TAG_BITS : 16;
	localparam int EW = 32 + TW;
	localparam logic [CW-1:0] DEPTH_C = CW'(HEAP_DEPTH);
	localparam logic [AW-1:0] LAST_A  = AW'(HEAP_DEPTH - 1);

	typedef enum logic [2:0] {
		ST_IDLE, ST_ARR, ST_INS_START, ST_INS, ST_INS_LAST, ST_DR_RD, ST_DR_EVAL, ST_DR_END
	} state_t;

	state_t state_q;

	logic [15:0] lost_timeout_q;
	logic [31:0] max_difference_q;
	logic [5:0]  max_releases_q;

	logic [31:0]   seq_q;
	logic [TW-1:0] tag_q;
	logic [AW-1:0] head_q  [2];
	logic [CW-1:0] count_q [2];
	logic          sel_q;
	logic          tb_q;
	logic          waiting_q;
	logic [31:0]   last_arr_q;
	logic [31:0]   last_rel_q;
	logic [15:0]   timer_q;
	logic [31:0]   losses_q;
	logic [15:0]   drops_q;
	logic [AW-1:0] cur_q;
	logic [AW-1:0] wr_q;
	logic [CW-1:0] rem_q;
	logic [5:0]    k_q;

	logic          ov_q;
	logic          kind_q;
	logic [31:0]   oseq_q;
	logic [TW-1:0] otag_q;
	logic [31:0]   oloss_q;
	logic [15:0]   odrop_q;
	logic          olast_q;

	function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] a);
		return (a == '0) ? LAST_A : a - AW'(1);
	endfunction

	function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] a);
		return (a == LAST_A) ? '0 : a + AW'(1);
	endfunction

	function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [CW-1:0] i);
		logic [CW:0] s;
		s = (CW+1)'(h) + (CW+1)'(i);
		if (s >= (CW+1)'(HEAP_DEPTH)) begin
			s = s - (CW+1)'(HEAP_DEPTH);
		end
		return s[AW-1:0];
	endfunction

	function automatic logic [31:0] dist32(input logic [31:0] a, input logic [31:0] b);
		return (a >= b) ? a - b : b - a;
	endfunction

	// ---------------------------------------------------------------- memory
	logic          we;
	logic [AW-1:0] waddr;
	logic [EW-1:0] wdata;
	logic [AW-1:0] raddr;
	logic [EW-1:0] rd0;
	logic [EW-1:0] rd1;
	logic [EW-1:0] rdata;

	psrb_ram #(.DEPTH(HEAP_DEPTH), .WIDTH(EW)) u_ram0 (
		.clk(clk), .we(we && !tb_q), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rd0)
	);

	psrb_ram #(.DEPTH(HEAP_DEPTH), .WIDTH(EW)) u_ram1 (
		.clk(clk), .we(we && tb_q), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rd1)
	);

	assign rdata = tb_q ? rd1 : rd0;

	logic [31:0]   rd_seq;
	logic [TW-1:0] rd_tag;
	logic          shift_up;
	logic [CW-1:0] tb_count;
	logic [AW-1:0] tb_head;

	assign rd_seq   = rdata[EW-1:TW];
	assign rd_tag   = rdata[TW-1:0];
	assign shift_up = rd_seq > seq_q;
	assign tb_count = count_q[tb_q];
	assign tb_head  = head_q[tb_q];

	always_comb begin
		we    = 1'b0;
		waddr = wr_q;
		wdata = {seq_q, tag_q};
		raddr = ptr_dec(cur_q);
		case (state_q)
			ST_INS_START: begin
				raddr = phys(tb_head, tb_count - CW'(1));
				if (tb_count == '0) begin
					we    = 1'b1;
					waddr = tb_head;
				end
			end
			ST_INS: begin
				we = 1'b1;
				if (shift_up) begin
					wdata = rdata;
				end
			end
			ST_INS_LAST: we = 1'b1;
			// keep the head word on the read port while the output stalls
			ST_DR_RD, ST_DR_EVAL: raddr = tb_head;
			default:     ;
		endcase
	end

	// ------------------------------------------------------- arrival checks
	logic jump;
	logic wait_n;
	assign jump   = (last_arr_q != '0) && (dist32(seq_q, last_arr_q) > max_difference_q);
	assign wait_n = jump || waiting_q;

	// --------------------------------------------------------- drain checks
	logic [31:0] sub;
	logic        hole;
	logic        slot_ok;
	logic        rel_fire;
	logic        ov_load;
	assign sub      = dist32(rd_seq, last_rel_q);
	assign hole     = (last_rel_q != '0) && (sub > 32'd1) && (sub < max_difference_q);
	assign slot_ok  = !ov_q || rsp.ready;
	assign rel_fire = !(hole && timer_q < lost_timeout_q)
		&& (hole || last_rel_q == '0 || rd_seq != last_rel_q);
	assign ov_load  = slot_ok && ((state_q == ST_DR_EVAL && rel_fire) || state_q == ST_DR_END);

	assign req.ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q[0] <= '0;
			count_q[1] <= '0;
			head_q[0]  <= '0;
			head_q[1]  <= '0;
			sel_q      <= 1'b0;
			tb_q       <= 1'b0;
			waiting_q  <= 1'b0;
			last_arr_q <= '0;
			last_rel_q <= '0;
			timer_q    <= '0;
			losses_q   <= '0;
			drops_q    <= '0;
			ov_q       <= 1'b0;
		end else begin
			if (ov_load) begin
				ov_q <= 1'b1;
			end else if (rsp.ready) begin
				ov_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						seq_q <= req.seq_num;
						tag_q <= req.payload_tag[TW-1:0];
						case (req.req_type)
							psrb_pkg::REQ_ARRIVE: state_q <= ST_ARR;
							psrb_pkg::REQ_TICK: begin
								if (timer_q != 16'hFFFF) begin
									timer_q <= timer_q + 16'd1;
								end
							end
							psrb_pkg::REQ_DRAIN: begin
								k_q     <= max_releases_q;
								tb_q    <= sel_q;
								state_q <= ST_DR_RD;
							end
							default: ;
						endcase
					end
				end
				ST_ARR: begin
					last_arr_q <= seq_q;
					if (jump && waiting_q) begin
						count_q[!sel_q] <= '0;
					end
					if (!wait_n) begin
						tb_q <= sel_q;
					end else if (count_q[sel_q] != '0) begin
						tb_q      <= !sel_q;
						waiting_q <= 1'b1;
					end else begin
						// main is empty: the side store takes its place
						sel_q     <= !sel_q;
						tb_q      <= !sel_q;
						waiting_q <= 1'b0;
					end
					state_q <= ST_INS_START;
				end
				ST_INS_START: begin
					if (tb_count == DEPTH_C) begin
						if (drops_q != 16'hFFFF) begin
							drops_q <= drops_q + 16'd1;
						end
						state_q <= ST_IDLE;
					end else if (tb_count == '0) begin
						count_q[tb_q] <= CW'(1);
						state_q       <= ST_IDLE;
					end else begin
						cur_q         <= raddr;
						wr_q          <= phys(tb_head, tb_count);
						rem_q         <= tb_count;
						count_q[tb_q] <= tb_count + CW'(1);
						state_q       <= ST_INS;
					end
				end
				ST_INS: begin
					if (shift_up) begin
						wr_q <= cur_q;
						if (rem_q == CW'(1)) begin
							state_q <= ST_INS_LAST;
						end else begin
							cur_q <= ptr_dec(cur_q);
							rem_q <= rem_q - CW'(1);
						end
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_INS_LAST: state_q <= ST_IDLE;
				ST_DR_RD: begin
					if (k_q == '0 || tb_count == '0) begin
						state_q <= ST_DR_END;
					end else begin
						state_q <= ST_DR_EVAL;
					end
				end
				ST_DR_EVAL: begin
					if (slot_ok) begin
						if (hole && timer_q < lost_timeout_q) begin
							state_q <= ST_DR_END;
						end else begin
							head_q[tb_q]  <= ptr_inc(tb_head);
							count_q[tb_q] <= tb_count - CW'(1);
							state_q       <= ST_DR_RD;
							// a duplicate is discarded without a word
							if (rel_fire) begin
								timer_q    <= '0;
								last_rel_q <= rd_seq;
								k_q        <= k_q - 6'd1;
								kind_q     <= psrb_pkg::KIND_PACKET;
								oseq_q     <= rd_seq;
								otag_q     <= rd_tag;
								oloss_q    <= hole ? losses_q + 32'd1 : losses_q;
								odrop_q    <= drops_q;
								olast_q    <= 1'b0;
								if (hole) begin
									losses_q <= losses_q + 32'd1;
								end
							end
						end
					end
				end
				ST_DR_END: begin
					if (slot_ok) begin
						kind_q  <= psrb_pkg::KIND_END;
						oseq_q  <= '0;
						otag_q  <= '0;
						oloss_q <= losses_q;
						odrop_q <= drops_q;
						olast_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign rsp.valid      = ov_q;
	assign rsp.kind       = kind_q;
	assign rsp.out_seq    = oseq_q;
	assign rsp.out_tag    = 16'(otag_q);
	assign rsp.loss_count = oloss_q;
	assign rsp.drop_count = odrop_q;
	assign rsp.last       = olast_q;

	// ------------------------------------------------------------ registers
	logic cfg_wr;
	assign cfg_wr = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lost_timeout_q   <= psrb_pkg::LOST_TIMEOUT_RST;
			max_difference_q <= psrb_pkg::MAX_DIFFERENCE_RST;
			max_releases_q   <= psrb_pkg::MAX_RELEASES_RST;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				psrb_pkg::REG_LOST_TIMEOUT:   lost_timeout_q   <= pwdata[15:0];
				psrb_pkg::REG_MAX_DIFFERENCE: max_difference_q <= pwdata;
				psrb_pkg::REG_MAX_RELEASES:   max_releases_q   <= pwdata[5:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			psrb_pkg::REG_LOST_TIMEOUT:   prdata = {16'd0, lost_timeout_q};
			psrb_pkg::REG_MAX_DIFFERENCE: prdata = max_difference_q;
			psrb_pkg::REG_MAX_RELEASES:   prdata = {26'd0, max_releases_q};
			default:                      prdata = '0;
		endcase
	end

`ifndef SYNTHESIS
	a_count0_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q[0] <= DEPTH_C) else $error("store 0 overfilled");
	a_count1_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q[1] <= DEPTH_C) else $error("store 1 overfilled");
	a_arr_to_ins: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ARR |=> state_q == ST_INS_START) else $error("arrival lost its insert");
	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !we) else $error("memory written while idle");
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q && olast_q |-> kind_q == psrb_pkg::KIND_END) else $error("last on packet word");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/psrb_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psrb_ram
// Simple dual-port memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module psrb_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 48
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire
